[rtl/core/bucketed_hash_table_top_assert.svh]
// Assertion macros used by the bucketed hash table checker
`ifndef BUCKETED_HASH_TABLE_TOP_ASSERT_SVH
`define BUCKETED_HASH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define BHT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define BHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/bht_pkg.sv]
// Types, sizes and codes shared by the bucketed hash table modules
`timescale 1ns / 1ps

package bht_pkg;

   localparam int NUM_BUCKETS      = 128;
   localparam int SLOTS_PER_BUCKET = 3;
   localparam int KEY_BITS         = 31;

   localparam int BUCKET_BITS = $clog2(NUM_BUCKETS);
   // divisor width: must hold NUM_BUCKETS itself
   localparam int EFF_BITS    = BUCKET_BITS + 1;
   localparam int FILL_BITS   = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int STEP_BITS   = $clog2(KEY_BITS);

   localparam int GPA_BITS         = 9;
   localparam int GPA_MAX          = 500;
   localparam int SIZE_BITS        = 8;
   localparam int TABLE_SIZE_RESET = 100;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_DELETED   = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // One bucket as stored in a memory row
   typedef struct packed {
      logic [FILL_BITS-1:0]                           fill;
      logic [SLOTS_PER_BUCKET-1:0][KEY_BITS-1:0]      keys;
      logic [SLOTS_PER_BUCKET-1:0][GPA_BITS-1:0]      grades;
   } row_type;

   // Outcome of one read-modify-write on a bucket
   typedef struct packed {
      status_type            status;
      logic [GPA_BITS-1:0]   removed_gpa;
      logic                  write_row;
      row_type               row;
   } update_type;

endpackage

[rtl/core/bht_divider.sv]
// Bit-serial restoring remainder unit: key modulo bucket count
`timescale 1ns / 1ps

module bht_divider
   import bht_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [KEY_BITS-1:0]    key,
   input  logic [EFF_BITS-1:0]    divisor,
   output logic                   done,
   output logic [BUCKET_BITS-1:0] remainder
);

   logic                   running_ff, running_in;
   logic                   done_ff, done_in;
   logic [STEP_BITS-1:0]   count_ff, count_in;
   logic [KEY_BITS-1:0]    dividend_ff, dividend_in;
   logic [BUCKET_BITS-1:0] rem_ff, rem_in;

   logic [EFF_BITS-1:0]    trial;
   logic [EFF_BITS-1:0]    diff;

   // one quotient bit per cycle, MSB of the key first
   assign trial = {rem_ff, dividend_ff[KEY_BITS-1]};
   assign diff  = trial - divisor;

   always_comb begin
      running_in  = running_ff;
      done_in     = 1'b0;
      count_in    = count_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      if (load) begin
         running_in  = 1'b1;
         count_in    = STEP_BITS'(KEY_BITS - 1);
         dividend_in = key;
         rem_in      = '0;
      end else if (running_ff) begin
         rem_in      = (trial >= divisor) ? diff[BUCKET_BITS-1:0] : trial[BUCKET_BITS-1:0];
         dividend_in = {dividend_ff[KEY_BITS-2:0], 1'b0};
         count_in    = count_ff - 1'b1;
         if (count_ff == '0) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         count_ff   <= count_in;
      end
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[rtl/core/bht_row_ram.sv]
// Bucket row memory: one write port, one registered read port
`timescale 1ns / 1ps

module bht_row_ram
   import bht_pkg::*;
(
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [BUCKET_BITS-1:0] wr_addr,
   input  row_type                wr_data,
   input  logic                   rd_en,
   input  logic [BUCKET_BITS-1:0] rd_addr,
   output row_type                rd_data
);

   row_type row_mem_ff [NUM_BUCKETS];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= row_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bht_row_update.sv]
// Bucket modify logic: append on insert, remove-and-close-gap on delete
`timescale 1ns / 1ps

module bht_row_update
   import bht_pkg::*;
(
   input  op_type              opcode,
   input  logic [KEY_BITS-1:0] key,
   input  logic [GPA_BITS-1:0] gpa,
   input  logic                row_valid,
   input  row_type             row,
   output update_type          upd
);

   logic [FILL_BITS-1:0]        fill;
   logic [GPA_BITS-1:0]         gpa_sat;
   logic [SLOTS_PER_BUCKET-1:0] shift;
   logic                        found;
   logic [GPA_BITS-1:0]         removed;
   row_type                     new_row;

   // a bucket never written since reset counts as empty; a larger fill is clamped to the slots
   always_comb begin
      fill = row_valid ? row.fill : '0;
      if (32'(fill) > SLOTS_PER_BUCKET) begin
         fill = FILL_BITS'(SLOTS_PER_BUCKET);
      end
   end

   assign gpa_sat = (gpa > GPA_BITS'(GPA_MAX)) ? GPA_BITS'(GPA_MAX) : gpa;

   // first live slot that matches; every slot from there on takes its successor
   always_comb begin
      found   = 1'b0;
      removed = '0;
      shift   = '0;
      for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
         if (!found && (FILL_BITS'(i) < fill) && (row.keys[i] == key)) begin
            found   = 1'b1;
            removed = row.grades[i];
         end
         shift[i] = found;
      end
   end

   always_comb begin
      new_row      = row;
      new_row.fill = fill;
      upd          = '0;
      unique case (opcode)
         OP_INSERT: begin
            if (32'(fill) >= SLOTS_PER_BUCKET) begin
               upd.status = ST_FULL;
            end else begin
               for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
                  if (FILL_BITS'(i) == fill) begin
                     new_row.keys[i]   = key;
                     new_row.grades[i] = gpa_sat;
                  end
               end
               new_row.fill  = fill + 1'b1;
               upd.status    = ST_INSERTED;
               upd.write_row = 1'b1;
            end
         end
         OP_DELETE: begin
            if (found) begin
               for (int i = 0; i < SLOTS_PER_BUCKET - 1; i++) begin
                  if (shift[i]) begin
                     new_row.keys[i]   = row.keys[i+1];
                     new_row.grades[i] = row.grades[i+1];
                  end
               end
               new_row.fill    = fill - 1'b1;
               upd.status      = ST_DELETED;
               upd.removed_gpa = removed;
               upd.write_row   = 1'b1;
            end else begin
               upd.status = ST_NOT_FOUND;
            end
         end
         default: begin
            upd.status = ST_NOT_FOUND;
         end
      endcase
      upd.row = new_row;
   end

endmodule

[rtl/core/bucketed_hash_table_top.sv]
// Top level of the bucketed hash table: control, config register, result beat
//
//  Channel  Ports                                     Direction  Beat taken when
//  req      start, busy, req_opcode/entry_key/gpa     in         start && !busy
//  rsp      rsp_valid, rsp_status/bucket_index/gpa    out        rsp_valid (no stall)
//  csr      csr_valid, csr_ready, csr_table_size      in         csr_valid && csr_ready
//
// An item passes through the bit-serial modulo unit (the key's 31 bits, one key bit each),
// then the row read, then the modify and write-back, then the hand-over of the result;
// no new item is taken until the last one is through.
// Result beat is shown for one cycle together with busy falling; start may be taken
// in that same cycle. Synchronous reset empties every bucket at once via per-bucket
// valid flops and sets the table size to 100.
`timescale 1ns / 1ps

module bucketed_hash_table_top
   import bht_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_opcode,
   input  logic [KEY_BITS-1:0]    req_entry_key,
   input  logic [GPA_BITS-1:0]    req_entry_gpa,
   // result
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [BUCKET_BITS-1:0] rsp_bucket_index,
   output logic [GPA_BITS-1:0]    rsp_removed_gpa,
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [SIZE_BITS-1:0]   csr_table_size
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_DIVIDE = 3'b010,
      S_UPDATE = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [SIZE_BITS-1:0]     table_size_ff;
   op_type                   opcode_ff;
   logic [KEY_BITS-1:0]      key_ff;
   logic [GPA_BITS-1:0]      gpa_ff;
   logic [BUCKET_BITS-1:0]   bucket_ff;
   logic [NUM_BUCKETS-1:0]   valid_ff;

   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic [BUCKET_BITS-1:0]   rsp_bucket_ff;
   logic [GPA_BITS-1:0]      rsp_gpa_ff;

   logic                     accept;
   logic [EFF_BITS-1:0]      eff_size;
   logic                     div_done;
   logic [BUCKET_BITS-1:0]   div_rem;
   row_type                  rd_row;
   update_type               upd;
   logic                     wr_en;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // zero acts as one bucket, oversize saturates to the table depth
   always_comb begin
      if (table_size_ff == '0) begin
         eff_size = EFF_BITS'(1);
      end else if (32'(table_size_ff) > NUM_BUCKETS) begin
         eff_size = EFF_BITS'(NUM_BUCKETS);
      end else begin
         eff_size = EFF_BITS'(table_size_ff);
      end
   end

   bht_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .key       (req_entry_key),
      .divisor   (eff_size),
      .done      (div_done),
      .remainder (div_rem)
   );

   bht_row_ram u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (bucket_ff),
      .wr_data (upd.row),
      .rd_en   (div_done),
      .rd_addr (div_rem),
      .rd_data (rd_row)
   );

   bht_row_update u_row_update (
      .opcode    (opcode_ff),
      .key       (key_ff),
      .gpa       (gpa_ff),
      .row_valid (valid_ff[bucket_ff]),
      .row       (rd_row),
      .upd       (upd)
   );

   assign wr_en = (state_ff == S_UPDATE) && upd.write_row;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (start) state_in = S_DIVIDE;
         S_DIVIDE: if (div_done) state_in = S_UPDATE;
         S_UPDATE: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         table_size_ff <= SIZE_BITS'(TABLE_SIZE_RESET);
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_UPDATE);
         if (csr_valid && csr_ready) begin
            table_size_ff <= csr_table_size;
         end
         if (wr_en) begin
            valid_ff[bucket_ff] <= 1'b1;
         end
      end
   end

   // request capture, bucket number and result beat
   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff <= op_type'(req_opcode);
         key_ff    <= req_entry_key;
         gpa_ff    <= req_entry_gpa;
      end
      if (div_done) begin
         bucket_ff <= div_rem;
      end
      if (state_ff == S_UPDATE) begin
         rsp_status_ff <= upd.status;
         rsp_bucket_ff <= bucket_ff;
         rsp_gpa_ff    <= upd.removed_gpa;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bucket_index = rsp_bucket_ff;
   assign rsp_removed_gpa  = rsp_gpa_ff;

endmodule

[rtl/core/bht_checker.sv]
// Port-level checker for the bucketed hash table, bound to the top level
`timescale 1ns / 1ps
`include "bucketed_hash_table_top_assert.svh"

module bht_checker
   import bht_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic [1:0]             rsp_status,
   input logic [GPA_BITS-1:0]    rsp_removed_gpa
);

   logic gpa_seen;
   logic gpa_ok;

   // a non-zero grade on a result beat, and what it must come with
   assign gpa_seen = rsp_valid && (rsp_removed_gpa != '0);
   assign gpa_ok   = (rsp_status == ST_DELETED) && (32'(rsp_removed_gpa) <= GPA_MAX);

   // an accepted request holds the block off the next cycle
   `BHT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised")

   // one beat per item: never two result cycles in a row
   `BHT_ASSERT_NEXT(a_single_beat, clock, reset, rsp_valid, !rsp_valid, "result repeated")

   // the block only goes idle by delivering its result
   `BHT_ASSERT_IMPLY(a_idle_result, clock, reset, $fell(busy) && !$past(reset), rsp_valid, "no result")

   // a grade comes back only for a delete that hit
   `BHT_ASSERT_IMPLY(a_gpa_status, clock, reset, gpa_seen, gpa_ok, "bad removed grade")

endmodule

bind bucketed_hash_table_top bht_checker u_bht_checker (.*);

[dv/tb.sv]
// Self-checking testbench for the bucketed hash table: queued stimulus, predictor, result check
`timescale 1ns / 1ps

module tb;
   import bht_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 50;
   localparam int REPORT_MAX   = 10;
   localparam int KEY_POOL_MAX = 48;

   // One queued command: an operation on the table or a new table size
   typedef struct packed {
      logic                  is_cfg;
      logic [SIZE_BITS-1:0]  size;
      op_type                op;
      logic [KEY_BITS-1:0]   key;
      logic [GPA_BITS-1:0]   gpa;
      logic                  calm;
   } table_cmd_type;

   // Predicted result beat
   typedef struct packed {
      status_type             status;
      logic [BUCKET_BITS-1:0] bucket;
      logic [GPA_BITS-1:0]    removed;
   } outcome_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_opcode = 1'b0;
   logic [KEY_BITS-1:0]    req_entry_key = '0;
   logic [GPA_BITS-1:0]    req_entry_gpa = '0;
   logic                   rsp_valid;
   logic [1:0]             rsp_status;
   logic [BUCKET_BITS-1:0] rsp_bucket_index;
   logic [GPA_BITS-1:0]    rsp_removed_gpa;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [SIZE_BITS-1:0]   csr_table_size = '0;

   table_cmd_type cmd_queue[$];
   outcome_type   outcome_queue[$];
   outcome_type   oldest;
   bit            calm_tail = 1'b0;
   bit            item_taken;
   bit            size_taken;
   int            idle_left;
   int            mismatch_count = 0;
   int            cycle_count = 0;

   // Shadow copy of the table
   int unsigned         model_size;
   int unsigned         model_fill [NUM_BUCKETS];
   logic [KEY_BITS-1:0] model_key  [NUM_BUCKETS][SLOTS_PER_BUCKET];
   logic [GPA_BITS-1:0] model_gpa  [NUM_BUCKETS][SLOTS_PER_BUCKET];

   bucketed_hash_table_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_entry_key    (req_entry_key),
      .req_entry_gpa    (req_entry_gpa),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_removed_gpa  (rsp_removed_gpa),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_table_size   (csr_table_size)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Size zero acts as one bucket, anything above the table saturates
   function automatic int unsigned buckets_in_use(int unsigned size);
      if (size == 0) return 1;
      if (size > NUM_BUCKETS) return NUM_BUCKETS;
      return size;
   endfunction

   // Apply one operation to the shadow table and return the result it gives
   function automatic outcome_type apply_to_table(op_type op, logic [KEY_BITS-1:0] key,
                                                  logic [GPA_BITS-1:0] gpa);
      int unsigned bkt;
      int unsigned fill;
      int          hit;
      outcome_type res;
      bkt = int'(key) % buckets_in_use(model_size);
      fill = model_fill[bkt];
      hit = -1;
      res.bucket = BUCKET_BITS'(bkt);
      res.removed = '0;
      if (op == OP_INSERT) begin
         if (fill >= SLOTS_PER_BUCKET) begin
            res.status = ST_FULL;
         end else begin
            model_key[bkt][fill] = key;
            model_gpa[bkt][fill] = (gpa > GPA_MAX) ? GPA_BITS'(GPA_MAX) : gpa;
            model_fill[bkt] = fill + 1;
            res.status = ST_INSERTED;
         end
      end else begin
         // oldest matching copy wins
         for (int i = 0; i < fill; i++) begin
            if (hit < 0 && model_key[bkt][i] == key) hit = i;
         end
         if (hit < 0) begin
            res.status = ST_NOT_FOUND;
         end else begin
            res.removed = model_gpa[bkt][hit];
            for (int i = hit; i + 1 < fill; i++) begin
               model_key[bkt][i] = model_key[bkt][i + 1];
               model_gpa[bkt][i] = model_gpa[bkt][i + 1];
            end
            model_fill[bkt] = fill - 1;
            res.status = ST_DELETED;
         end
      end
      return res;
   endfunction

   function automatic void add_op(op_type op, logic [KEY_BITS-1:0] key,
                                  logic [GPA_BITS-1:0] gpa);
      table_cmd_type c;
      c.is_cfg = 1'b0;
      c.size = '0;
      c.op = op;
      c.key = key;
      c.gpa = gpa;
      c.calm = calm_tail;
      cmd_queue.push_back(c);
   endfunction

   function automatic void add_resize(logic [SIZE_BITS-1:0] size);
      table_cmd_type c;
      c.is_cfg = 1'b1;
      c.size = size;
      c.op = OP_INSERT;
      c.key = '0;
      c.gpa = '0;
      c.calm = calm_tail;
      cmd_queue.push_back(c);
   endfunction

   // Driver: offers queued beats, predicts each accepted operation
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         model_size = TABLE_SIZE_RESET;
         foreach (model_fill[b]) model_fill[b] = 0;
         idle_left = 0;
      end else begin
         item_taken = start && !busy;
         size_taken = csr_valid && csr_ready;
         if (item_taken) begin
            outcome_queue.push_back(apply_to_table(op_type'(req_opcode), req_entry_key,
                                                   req_entry_gpa));
            void'(cmd_queue.pop_front());
         end
         if (size_taken) begin
            model_size = 32'(csr_table_size);
            void'(cmd_queue.pop_front());
         end
         if ((start && !item_taken) || (csr_valid && !size_taken)) begin
            // beat still on offer: hold it
         end else if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
            csr_valid <= 1'b0;
         end else if (cmd_queue.size() == 0) begin
            start <= 1'b0;
            csr_valid <= 1'b0;
         end else if (cmd_queue[0].is_cfg) begin
            // size only changes once every result is back
            start <= 1'b0;
            csr_valid <= (outcome_queue.size() == 0);
            csr_table_size <= cmd_queue[0].size;
         end else if (!cmd_queue[0].calm && $urandom_range(0, 3) == 0) begin
            // idle burst of random length: this cycle idles, idle_left counts down the rest
            idle_left = $urandom_range(1, 8) - 1;
            start <= 1'b0;
            csr_valid <= 1'b0;
         end else begin
            start <= 1'b1;
            csr_valid <= 1'b0;
            req_opcode <= cmd_queue[0].op;
            req_entry_key <= cmd_queue[0].key;
            req_entry_gpa <= cmd_queue[0].gpa;
         end
      end
   end

   // Monitor: every result beat is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (outcome_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected result beat: status %0d bucket %0d gpa %0d",
                        rsp_status, rsp_bucket_index, rsp_removed_gpa);
         end else begin
            oldest = outcome_queue.pop_front();
            if (rsp_status !== oldest.status || rsp_bucket_index !== oldest.bucket ||
                rsp_removed_gpa !== oldest.removed) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("mismatch: status %0d/%0d bucket %0d/%0d gpa %0d/%0d (exp/act)",
                           oldest.status, rsp_status, oldest.bucket, rsp_bucket_index,
                           oldest.removed, rsp_removed_gpa);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      logic [KEY_BITS-1:0] live_keys[$];
      logic [KEY_BITS-1:0] key;
      int unsigned         sz;
      int unsigned         span;
      op_type              op;

      // Directed: bucket overflow, order kept on delete, duplicates, saturation
      add_op(OP_INSERT, 31'd0, 9'd0);
      add_op(OP_INSERT, 31'h7FFF_FFFF, 9'h1FF);
      add_op(OP_INSERT, 31'd100, 9'd500);
      add_op(OP_INSERT, 31'd200, 9'd1);
      add_op(OP_INSERT, 31'd300, 9'd42);
      add_op(OP_DELETE, 31'd100, 9'h1FF);
      add_op(OP_DELETE, 31'd300, 9'd0);
      add_op(OP_INSERT, 31'd0, 9'd123);
      add_op(OP_DELETE, 31'd0, 9'h0AA);
      add_op(OP_DELETE, 31'd0, 9'h155);
      add_op(OP_DELETE, 31'd200, 9'd0);
      add_op(OP_DELETE, 31'd200, 9'd0);
      add_op(OP_DELETE, 31'h7FFF_FFFF, 9'd0);
      // size zero folds onto one bucket
      add_resize(8'd0);
      add_op(OP_INSERT, 31'd55, 9'd501);
      add_op(OP_INSERT, 31'h2AAA_AAAA, 9'h155);
      add_op(OP_DELETE, 31'h5555_5555, 9'h1FF);
      // oversize saturates
      add_resize(8'd255);
      add_op(OP_INSERT, 31'd127, 9'd300);
      add_op(OP_INSERT, 31'd255, 9'd400);
      add_op(OP_DELETE, 31'd127, 9'd0);
      // entries stay put across a resize
      add_resize(8'd1);
      add_op(OP_DELETE, 31'd55, 9'd0);
      add_resize(8'd128);
      add_op(OP_DELETE, 31'h2AAA_AAAA, 9'd0);

      // Random phases, each under its own table size
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: sz = 3;
            1: sz = 128;
            2: sz = $urandom_range(1, 8);
            3: sz = 0;
            4: sz = 255;
            5: sz = $urandom_range(9, 127);
            6: sz = $urandom_range(129, 255);
            default: sz = $urandom_range(1, 4);
         endcase
         add_resize(SIZE_BITS'(sz));
         span = buckets_in_use(sz);
         if (phase == 7) calm_tail = 1'b1;
         for (int n = 0; n < 210; n++) begin
            op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_DELETE;
            if ($urandom_range(0, 9) == 0) begin
               // noise: any key at all
               key = KEY_BITS'($urandom);
            end else if (op == OP_DELETE && live_keys.size() != 0 &&
                         $urandom_range(0, 3) != 0) begin
               key = live_keys[$urandom_range(0, live_keys.size() - 1)];
            end else if ($urandom_range(0, 1) == 0) begin
               key = KEY_BITS'($urandom_range(0, span * 6 - 1));
            end else begin
               key = 31'h7FFF_FFFF - KEY_BITS'($urandom_range(0, span * 6 - 1));
            end
            if (op == OP_INSERT) begin
               live_keys.push_back(key);
               if (live_keys.size() > KEY_POOL_MAX) void'(live_keys.pop_front());
            end
            add_op(op, key, GPA_BITS'($urandom_range(0, 511)));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() != 0 || outcome_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/bht_pkg.sv
rtl/core/bht_divider.sv
rtl/core/bht_row_ram.sv
rtl/core/bht_row_update.sv
rtl/core/bucketed_hash_table_top.sv
rtl/core/bht_checker.sv
dv/tb.sv
